@@ hdl/double_step_line_rasterizer_defines.svh @@
// Assertion macros for the double-step line rasterizer.
`ifndef DOUBLE_STEP_LINE_RASTERIZER_DEFINES_SVH
`define DOUBLE_STEP_LINE_RASTERIZER_DEFINES_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define DSLR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the following cycle.
`define DSLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dslr_pkg.sv @@
// Shared types and constants of the double-step line rasterizer.
package dslr_pkg;

  localparam int unsigned CoordBitsDef = 8;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_OUT
  } state_e;

  // Pixel sequencer phases of a sloped line
  typedef enum logic [1:0] {
    PH_FIRST,   // first endpoint
    PH_SECOND,  // second endpoint
    PH_LOOP,    // two pixels from each end per iteration
    PH_LEFT     // leftover pixels
  } phase_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture a new line command
    logic setup;   // derive spans, increments and cursors
    logic advance; // produce the next pixel into the group
    logic flush;   // group word taken, clear the group
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last_pix;  // pixel produced now is the last of the line
    logic grp_fill;  // pixel produced now fills the group
  } dp_sts_t;

endpackage

@@ hdl/dslr_datapath.sv @@
// Datapath: line setup, pixel sequencing and group assembly.
module dslr_datapath #(
  parameter int unsigned CoordBits = dslr_pkg::CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dslr_pkg::dp_cmd_t    cmd_i,
  output dslr_pkg::dp_sts_t    sts_o,
  input  logic [7:0]           start_x_i,
  input  logic [7:0]           start_y_i,
  input  logic [7:0]           end_x_i,
  input  logic [7:0]           end_y_i,
  input  logic [7:0]           pen_color_i,
  output logic [7:0]           grp_x_o [4],
  output logic [7:0]           grp_y_o [4],
  output logic [2:0]           grp_cnt_o,
  output logic [7:0]           grp_color_o
);

  localparam int unsigned CB = CoordBits;
  localparam int unsigned DB = CB + 4;   // signed decision width

  // Captured command
  logic [CB-1:0] a1_q, b1_q, a2_q, b2_q;
  logic [7:0]    color_q;

  // Line state
  logic [CB-1:0] x_q, y_q, x1_q, y1_q;
  logic [CB-1:0] run_end_q;
  logic signed [DB-1:0] dec_q, inca_q, incb_q, split_q;
  logic [CB-1:0] iter_q;
  logic [1:0]    left_q;
  logic          axis_q, rev_q, down_q, steep_q;
  dslr_pkg::phase_e phase_q;
  logic [1:0]    sub_q;      // pixel index within iteration / leftover
  logic [2:0]    cnt_q;

  logic [7:0]    gx_q [4];
  logic [7:0]    gy_q [4];

  // Setup arithmetic
  logic [CB-1:0] sa1, sb1, sa2, sb2, adx, ady, mdx, mdy;
  logic          sdown, srev;
  logic [CB-1:0] dxm1;
  logic signed [DB-1:0] sdx, sdy, sc, sincb;

  always_comb begin
    sdown = (a2_q < a1_q) != (b2_q < b1_q);
    adx = (a2_q >= a1_q) ? a2_q - a1_q : a1_q - a2_q;
    ady = (b2_q >= b1_q) ? b2_q - b1_q : b1_q - b2_q;
    srev = ady > adx;
    sa1 = srev ? b1_q : a1_q;
    sb1 = srev ? a1_q : b1_q;
    sa2 = srev ? b2_q : a2_q;
    sb2 = srev ? a2_q : b2_q;
    mdx = srev ? ady : adx;
    mdy = srev ? adx : ady;
    dxm1 = mdx - CB'(1);
    sdx = DB'(mdx);
    sdy = DB'(mdy);
    sincb = (sdy <<< 2) - (sdx <<< 1);
    sc = sincb[DB-1] ? (sdy <<< 1) : ((sdy - sdx) <<< 1);
  end

  // Pattern of the current iteration
  logic dlow, pnone, pboth, s0, s1, use_a;
  always_comb begin
    dlow  = dec_q < split_q;
    pnone = !steep_q && dec_q[DB-1];
    pboth = steep_q && !dec_q[DB-1] && (dec_q != '0);
    // first pixel of a side steps on the high pattern, second on the low one
    s0    = !pnone && (pboth || !dlow);
    s1    = !pnone && (pboth || dlow);
    use_a = pnone || pboth;
  end

  // Pixel emission for current step
  logic [CB-1:0] pm, pn, nx, ny, nx1, ny1;
  logic [CB-1:0] stp;
  logic          last_pix;
  logic          fwd_side, ystep;

  always_comb begin
    stp = down_q ? {CB{1'b1}} : CB'(1);
    nx = x_q; ny = y_q; nx1 = x1_q; ny1 = y1_q;
    pm = x_q; pn = y_q;
    fwd_side = 1'b1; ystep = 1'b0;
    last_pix = 1'b0;
    if (axis_q) begin
      nx = x_q + CB'(1);
      last_pix = (x_q == run_end_q);
    end else begin
      unique case (phase_q)
        dslr_pkg::PH_FIRST: begin
          last_pix = 1'b0;
        end
        dslr_pkg::PH_SECOND: begin
          pm = x1_q; pn = y1_q;
          last_pix = (iter_q == '0) && (left_q == 2'd0);
        end
        dslr_pkg::PH_LOOP: begin
          // sub: 0,1 forward; 2,3 backward
          fwd_side = !sub_q[1];
          ystep = sub_q[0] ? s1 : s0;
          last_pix = (sub_q == 2'd3) && (iter_q == CB'(1)) && (left_q == 2'd0);
        end
        dslr_pkg::PH_LEFT: begin
          // leftover: sub 0,1 forward, 2 backward
          fwd_side = !sub_q[1];
          ystep = sub_q[0] ? s1 : s0;
          // steep high pattern: backward pixel steps only above the split
          if (sub_q[1] && steep_q && !pboth && !dlow) ystep = dec_q > split_q;
          last_pix = (sub_q == left_q - 2'd1);
        end
      endcase
      if (phase_q == dslr_pkg::PH_LOOP || phase_q == dslr_pkg::PH_LEFT) begin
        if (fwd_side) begin
          nx = x_q + CB'(1);
          ny = ystep ? y_q + stp : y_q;
          pm = nx; pn = ny;
        end else begin
          nx1 = x1_q - CB'(1);
          ny1 = ystep ? y1_q - stp : y1_q;
          pm = nx1; pn = ny1;
        end
      end
    end
  end

  logic [7:0] px, py;
  assign px = 8'(rev_q ? pn : pm);
  assign py = 8'(rev_q ? pm : pn);

  // Line registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_q <= '0; b1_q <= '0; a2_q <= '0; b2_q <= '0;
      color_q <= '0;
      x_q <= '0; y_q <= '0; x1_q <= '0; y1_q <= '0;
      run_end_q <= '0;
      dec_q <= '0; inca_q <= '0; incb_q <= '0; split_q <= '0;
      iter_q <= '0; left_q <= '0;
      axis_q <= 1'b0; rev_q <= 1'b0; down_q <= 1'b0; steep_q <= 1'b0;
      phase_q <= dslr_pkg::PH_FIRST;
      sub_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      a1_q <= CB'(start_x_i); b1_q <= CB'(start_y_i);
      a2_q <= CB'(end_x_i);   b2_q <= CB'(end_y_i);
      color_q <= pen_color_i;
      cnt_q <= '0;
    end else if (cmd_i.setup) begin
      axis_q <= (a1_q == a2_q) || (b1_q == b2_q);
      phase_q <= dslr_pkg::PH_FIRST;
      sub_q <= '0;
      if (a1_q == a2_q) begin
        rev_q <= 1'b1; x_q <= (b1_q < b2_q) ? b1_q : b2_q;
        run_end_q <= (b1_q < b2_q) ? b2_q : b1_q; y_q <= a1_q;
      end else if (b1_q == b2_q) begin
        rev_q <= 1'b0; x_q <= (a1_q < a2_q) ? a1_q : a2_q;
        run_end_q <= (a1_q < a2_q) ? a2_q : a1_q; y_q <= b1_q;
      end else begin
        rev_q <= srev;
        run_end_q <= '0;
        if (sa1 > sa2) begin
          x_q <= sa2; y_q <= sb2; x1_q <= sa1; y1_q <= sb1;
        end else begin
          x_q <= sa1; y_q <= sb1; x1_q <= sa2; y1_q <= sb2;
        end
      end
      down_q  <= sdown;
      steep_q <= !sincb[DB-1];
      incb_q  <= sincb;
      inca_q  <= sc <<< 1;
      split_q <= sc;
      dec_q   <= sincb[DB-1] ? (sc <<< 1) - sdx : (sc <<< 1) + sdx;
      iter_q  <= dxm1 >> 2;
      left_q  <= dxm1[1:0];
    end else if (cmd_i.advance) begin
      cnt_q <= cnt_q + 3'd1;
      x_q <= nx; y_q <= ny; x1_q <= nx1; y1_q <= ny1;
      if (!axis_q) begin
        unique case (phase_q)
          dslr_pkg::PH_FIRST: phase_q <= dslr_pkg::PH_SECOND;
          dslr_pkg::PH_SECOND: begin
            phase_q <= (iter_q != '0) ? dslr_pkg::PH_LOOP : dslr_pkg::PH_LEFT;
            sub_q <= '0;
          end
          dslr_pkg::PH_LOOP: begin
            sub_q <= sub_q + 2'd1;
            if (sub_q == 2'd3) begin
              iter_q <= iter_q - CB'(1);
              dec_q <= dec_q + (use_a ? inca_q : incb_q);
              if (iter_q == CB'(1)) phase_q <= dslr_pkg::PH_LEFT;
            end
          end
          dslr_pkg::PH_LEFT: sub_q <= sub_q + 2'd1;
        endcase
      end
    end else if (cmd_i.flush) begin
      cnt_q <= '0;
    end
  end

  // Group buffer: unused slots read as zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.load || cmd_i.flush) begin
      for (int k = 0; k < 4; k++) begin gx_q[k] <= '0; gy_q[k] <= '0; end
    end else if (cmd_i.advance) begin
      gx_q[cnt_q[1:0]] <= px; gy_q[cnt_q[1:0]] <= py;
    end
  end

  assign sts_o.last_pix = last_pix;
  assign sts_o.grp_fill = (cnt_q == 3'd3);
  assign grp_x_o     = gx_q;
  assign grp_y_o     = gy_q;
  assign grp_cnt_o   = cnt_q;
  assign grp_color_o = color_q;

endmodule

@@ hdl/dslr_ctrl.sv @@
// Controller: sequences setup, pixel steps and group hand-off.
`include "double_step_line_rasterizer_defines.svh"
module dslr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               out_last_o,
  output dslr_pkg::dp_cmd_t  cmd_o,
  input  dslr_pkg::dp_sts_t  sts_i
);

  dslr_pkg::state_e state_q, state_d;
  logic last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dslr_pkg::ST_IDLE;
      last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q <= last_d;
    end
  end

  // Advance one pixel per cycle; hold while a finished group waits
  always_comb begin
    state_d = state_q;
    last_d = last_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      dslr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          last_d = 1'b0;
          state_d = dslr_pkg::ST_SETUP;
        end
      end
      dslr_pkg::ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d = dslr_pkg::ST_RUN;
      end
      dslr_pkg::ST_RUN: begin
        cmd_o.advance = 1'b1;
        if (sts_i.last_pix || sts_i.grp_fill) begin
          last_d = sts_i.last_pix;
          state_d = dslr_pkg::ST_OUT;
        end
      end
      dslr_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          cmd_o.flush = 1'b1;
          state_d = last_q ? dslr_pkg::ST_IDLE : dslr_pkg::ST_RUN;
        end
      end
    endcase
  end

  assign out_valid_o = (state_q == dslr_pkg::ST_OUT);
  assign out_last_o  = last_q;

  `DSLR_ASSERT_IMP(a_no_adv_idle, clk_i, rst_ni, !in_stall_o, !cmd_o.advance, "advance while idle")
  `DSLR_ASSERT_NEXT(a_load_setup, clk_i, rst_ni, cmd_o.load, cmd_o.setup, "load not followed by setup")
  `DSLR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "word dropped")
  `DSLR_ASSERT_IMP(a_flush_acc, clk_i, rst_ni, cmd_o.flush, out_valid_o && !out_stall_i, "bad flush")

endmodule

@@ hdl/double_step_line_rasterizer.sv @@
// Top level of the double-step line rasterizer.
// channel | direction | handshake                 | payload
// line    | in        | in_valid_i / in_stall_o   | start/end x,y, pen_color
// group   | out       | out_valid_o / out_stall_i | pix0..3 x,y, count, color, last
// A line is accepted, then set up; its pixels are then produced one per cycle
// into groups of up to four, except while a group word waits to be handed off.
// The sequencer holds while a group word is stalled.
// Reset clears the controller and line state; the group clears on each new line.
module double_step_line_rasterizer #(
  parameter int unsigned CoordBits = dslr_pkg::CoordBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] start_x_i,
  input  logic [7:0] start_y_i,
  input  logic [7:0] end_x_i,
  input  logic [7:0] end_y_i,
  input  logic [7:0] pen_color_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] pix0_x_o,
  output logic [7:0] pix0_y_o,
  output logic [7:0] pix1_x_o,
  output logic [7:0] pix1_y_o,
  output logic [7:0] pix2_x_o,
  output logic [7:0] pix2_y_o,
  output logic [7:0] pix3_x_o,
  output logic [7:0] pix3_y_o,
  output logic [2:0] pixel_count_o,
  output logic [7:0] pixel_color_o,
  output logic       last_group_o
);

  dslr_pkg::dp_cmd_t cmd;
  dslr_pkg::dp_sts_t sts;
  logic [7:0] gx [4];
  logic [7:0] gy [4];

  dslr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .out_last_o(last_group_o), .cmd_o(cmd), .sts_i(sts)
  );

  dslr_datapath #(.CoordBits(CoordBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .start_x_i, .start_y_i, .end_x_i, .end_y_i, .pen_color_i,
    .grp_x_o(gx), .grp_y_o(gy), .grp_cnt_o(pixel_count_o),
    .grp_color_o(pixel_color_o)
  );

  assign pix0_x_o = gx[0]; assign pix0_y_o = gy[0];
  assign pix1_x_o = gx[1]; assign pix1_y_o = gy[1];
  assign pix2_x_o = gx[2]; assign pix2_y_o = gy[2];
  assign pix3_x_o = gx[3]; assign pix3_y_o = gy[3];

endmodule

@@ verif/testbench.sv @@
// Regression bench for the double-step line rasterizer: directed and random lines.
`timescale 1ns / 1ps
module testbench;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] start_x_i = '0, start_y_i = '0, end_x_i = '0, end_y_i = '0;
  logic [7:0] pen_color_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b1;
  logic [7:0] pix0_x_o, pix0_y_o, pix1_x_o, pix1_y_o;
  logic [7:0] pix2_x_o, pix2_y_o, pix3_x_o, pix3_y_o;
  logic [2:0] pixel_count_o;
  logic [7:0] pixel_color_o;
  logic       last_group_o;

  typedef struct packed {
    logic [3:0][7:0] px;
    logic [3:0][7:0] py;
    logic [2:0]      cnt;
    logic [7:0]      color;
    logic            last;
  } group_t;

  group_t     group_q[$];
  int         errors = 0;
  logic [7:0] line_px[$], line_py[$];
  bit         swap_axes;

  double_step_line_rasterizer dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // Plot one pixel given in major/minor terms
  function automatic void plot(int maj, int mnr);
    if (swap_axes) begin
      line_px.push_back(mnr[7:0]);
      line_py.push_back(maj[7:0]);
    end else begin
      line_px.push_back(maj[7:0]);
      line_py.push_back(mnr[7:0]);
    end
  endfunction

  // Symmetric double-step walk of a sloped line
  function automatic void walk_sloped(int a1, int b1, int a2, int b2);
    int dx, dy, sx, sy, stp, t, x, y, x1, y1, c, d, ia, ib, iters, rem;
    dx = a2 - a1; dy = b2 - b1; sx = 1; sy = 1;
    if (dx < 0) begin sx = -1; dx = -dx; end
    if (dy < 0) begin sy = -1; dy = -dy; end
    stp = (sx == sy) ? 1 : -1;
    swap_axes = 0;
    if (dy > dx) begin
      t = a1; a1 = b1; b1 = t;
      t = a2; a2 = b2; b2 = t;
      t = dx; dx = dy; dy = t;
      swap_axes = 1;
    end
    if (a1 > a2) begin x = a2; y = b2; x1 = a1; y1 = b1; end
    else begin x = a1; y = b1; x1 = a2; y1 = b2; end
    iters = (dx - 1) / 4;
    rem = (dx - 1) % 4;
    plot(x, y);
    plot(x1, y1);
    ib = 4 * dy - 2 * dx;
    if (ib < 0) begin
      c = 2 * dy; ia = 2 * c; d = ia - dx;
      for (int i = iters; i > 0; i--) begin
        x++; x1--;
        if (d < 0) begin
          plot(x, y); x++; plot(x, y);
          plot(x1, y1); x1--; plot(x1, y1);
          d += ia;
        end else begin
          if (d < c) begin
            plot(x, y); x++; y += stp; plot(x, y);
            plot(x1, y1); x1--; y1 -= stp; plot(x1, y1);
          end else begin
            y += stp; plot(x, y); x++; plot(x, y);
            y1 -= stp; plot(x1, y1); x1--; plot(x1, y1);
          end
          d += ib;
        end
      end
      if (rem != 0) begin
        if (d < 0) begin
          x++; plot(x, y);
          if (rem > 1) begin x++; plot(x, y); end
          if (rem > 2) begin x1--; plot(x1, y1); end
        end else if (d < c) begin
          x++; plot(x, y);
          if (rem > 1) begin x++; y += stp; plot(x, y); end
          if (rem > 2) begin x1--; plot(x1, y1); end
        end else begin
          x++; y += stp; plot(x, y);
          if (rem > 1) begin x++; plot(x, y); end
          if (rem > 2) begin x1--; y1 -= stp; plot(x1, y1); end
        end
      end
    end else begin
      c = 2 * (dy - dx); ia = 2 * c; d = ia + dx;
      for (int i = iters; i > 0; i--) begin
        x++; x1--;
        if (d > 0) begin
          y += stp; plot(x, y); x++; y += stp; plot(x, y);
          y1 -= stp; plot(x1, y1); x1--; y1 -= stp; plot(x1, y1);
          d += ia;
        end else begin
          if (d < c) begin
            plot(x, y); x++; y += stp; plot(x, y);
            plot(x1, y1); x1--; y1 -= stp; plot(x1, y1);
          end else begin
            y += stp; plot(x, y); x++; plot(x, y);
            y1 -= stp; plot(x1, y1); x1--; plot(x1, y1);
          end
          d += ib;
        end
      end
      if (rem != 0) begin
        if (d > 0) begin
          x++; y += stp; plot(x, y);
          if (rem > 1) begin x++; y += stp; plot(x, y); end
          if (rem > 2) begin x1--; y1 -= stp; plot(x1, y1); end
        end else if (d < c) begin
          x++; plot(x, y);
          if (rem > 1) begin x++; y += stp; plot(x, y); end
          if (rem > 2) begin x1--; plot(x1, y1); end
        end else begin
          x++; y += stp; plot(x, y);
          if (rem > 1) begin x++; plot(x, y); end
          if (rem > 2) begin
            x1--;
            if (d > c) y1 -= stp;
            plot(x1, y1);
          end
        end
      end
    end
  endfunction

  // Rasterize one line and queue its pixel groups
  function automatic void predict_groups(int ax, int ay, int bx, int by, logic [7:0] col);
    int lo, hi, n, ng, cnt;
    group_t g;
    line_px.delete();
    line_py.delete();
    swap_axes = 0;
    if (ax == bx || ay == by) begin
      lo = (ax == bx) ? ay : ax;
      hi = (ax == bx) ? by : bx;
      if (lo > hi) begin n = lo; lo = hi; hi = n; end
      for (int i = lo; i <= hi; i++)
        if (ax == bx) plot(ax, i);
        else plot(i, ay);
    end else begin
      walk_sloped(ax, ay, bx, by);
    end
    n = line_px.size();
    ng = (n + 3) / 4;
    for (int gi = 0; gi < ng; gi++) begin
      g = '0;
      cnt = (n - 4 * gi > 4) ? 4 : n - 4 * gi;
      for (int k = 0; k < cnt; k++) begin
        g.px[k] = line_px[4 * gi + k];
        g.py[k] = line_py[4 * gi + k];
      end
      g.cnt = cnt[2:0];
      g.color = col;
      g.last = (gi == ng - 1);
      group_q.push_back(g);
    end
  endfunction

  // Send one line command after a random gap; returns at the accepting edge
  task automatic send_line(int ax, int ay, int bx, int by, int col);
    int gap;
    gap = $urandom_range(10);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_x_i <= ax[7:0]; start_y_i <= ay[7:0];
    end_x_i <= bx[7:0]; end_y_i <= by[7:0];
    pen_color_i <= col[7:0];
    in_valid_i <= 1'b1;
    predict_groups(ax, ay, bx, by, col[7:0]);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (group_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Output side: hold each word stalled for a random wait before taking it
  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (out_valid_o) begin
        wait_n = $urandom_range(10);
        repeat (wait_n) @(negedge clk_i);
        out_stall_i <= 1'b0;
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
    end
  end

  // Compare each accepted word with the oldest expected group
  always @(posedge clk_i) begin
    group_t want, got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.px = {pix3_x_o, pix2_x_o, pix1_x_o, pix0_x_o};
      got.py = {pix3_y_o, pix2_y_o, pix1_y_o, pix0_y_o};
      got.cnt = pixel_count_o;
      got.color = pixel_color_o;
      got.last = last_group_o;
      if (group_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none actual %h", $time, got);
      end else begin
        want = group_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
        end
      end
    end
  end

  task automatic test_directed();
    send_line(7, 7, 7, 7, 8'h00);       // single pixel
    send_line(0, 0, 255, 0, 8'hff);     // full horizontal
    send_line(255, 255, 255, 0, 8'h5a); // full vertical, descending
    send_line(0, 0, 255, 255, 8'ha5);   // diagonal
    send_line(255, 0, 0, 255, 8'h01);   // anti-diagonal
    send_line(0, 0, 255, 1, 8'h80);     // shallow
    send_line(0, 255, 1, 0, 8'h7f);     // steep
    send_line(10, 10, 11, 11, 8'h33);
    send_line(10, 10, 12, 11, 8'h44);
    send_line(10, 10, 13, 11, 8'h55);
    send_line(10, 10, 14, 12, 8'h66);
    send_line(30, 20, 20, 27, 8'h77);
    send_line(5, 100, 200, 0, 8'h88);
    send_line(200, 3, 9, 140, 8'h99);
    send_line(0, 0, 9, 6, 8'h12);
    send_line(0, 0, 10, 7, 8'h34);
    send_line(3, 4, 3, 5, 8'h56);
    wait_drained();
  endtask

  task automatic test_random(int n);
    int ax, ay, span;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(4) == 0) begin
        send_line($urandom_range(255), $urandom_range(255), $urandom_range(255),
                  $urandom_range(255), $urandom_range(255));
      end else begin
        span = $urandom_range(24);
        ax = $urandom_range(255); ay = $urandom_range(255);
        send_line(ax, ay, (ax + $urandom_range(2 * span) - span) & 255,
                  (ay + $urandom_range(2 * span) - span) & 255, $urandom_range(255));
      end
      // hold off until the block drains once mid-run
      if (i == n / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(100);
    if (errors == 0) $display("double_step_line_rasterizer regression: pass");
    else $display("double_step_line_rasterizer regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("double_step_line_rasterizer regression: fail");
    $finish;
  end

endmodule
